@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL, compiled away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/tvbe_pkg.sv @@
// Types, constants and functions for the TEA-style block encryption pipeline.
package tvbe_pkg;

    localparam int WordWidth = 32;
    localparam logic [WordWidth-1:0] MixDelta = 32'h9E3779B9;

    typedef logic [WordWidth-1:0] word_t;

    typedef struct packed {
        logic  valid;
        word_t upd;
        word_t src;
    } tvbe_stage_t;

    function automatic word_t round_sum(input logic [6:0] round_idx);
        word_t count;
        count = word_t'(round_idx) + word_t'(1);
        return MixDelta * count;
    endfunction

endpackage

@@ src/tvbe_half_round.sv @@
// One registered half-round: mixes the source word into the updated word and swaps them.
module tvbe_half_round
    import tvbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  word_t       sum,
    input  word_t       key_a,
    input  word_t       key_b,
    input  tvbe_stage_t stage_in,
    output tvbe_stage_t stage_out
);

    logic  valid_reg;
    word_t upd_reg;
    word_t src_reg;
    word_t mix;
    word_t upd_next;

    assign mix = ((stage_in.src << 4) + key_a)
               ^ (stage_in.src + sum)
               ^ ((stage_in.src >> 5) + key_b);
    assign upd_next = stage_in.upd + mix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // The updated word becomes the source of the next half-round.
    always_ff @(posedge clk)
    begin
        upd_reg <= stage_in.src;
        src_reg <= upd_next;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.upd   = upd_reg;
    assign stage_out.src   = src_reg;

endmodule

@@ src/tea_variant_block_encrypt.sv @@
// Top level of the pipelined TEA-style 64-bit block encryptor.
// A request is taken in every clock cycle; busy stays low. Each request runs through
// 2*ROUND_COUNT register stages, one half-round each, and its result appears with done
// in request order. The result is shown for one cycle only and the receiver cannot
// stall it. Write the key only while no request is in the pipeline.
`include "assert_macros.svh"

module tea_variant_block_encrypt
    import tvbe_pkg::*;
#(
    parameter int ROUND_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] plain_first_word,
    input  logic [31:0] plain_second_word,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output logic        done,
    output logic [31:0] cipher_first_word,
    output logic [31:0] cipher_second_word
);

    localparam int Latency = 2 * ROUND_COUNT;

    word_t       base_key_reg;
    word_t       base_key_next;
    word_t       key0;
    word_t       key1;
    word_t       key2;
    word_t       key3;
    tvbe_stage_t stage_q [0:Latency];

    assign base_key_next = cfg_wr_en ? cfg_wr_data : base_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_key_reg <= '0;
        end
        else
        begin
            base_key_reg <= base_key_next;
        end
    end

    assign key0 = base_key_reg;
    assign key1 = {base_key_reg[23:0], base_key_reg[31:24]};
    assign key2 = {base_key_reg[15:0], base_key_reg[31:16]};
    assign key3 = {base_key_reg[7:0], base_key_reg[31:8]};

    assign busy = 1'b0;

    assign stage_q[0].valid = start & ~busy;
    assign stage_q[0].upd   = plain_first_word;
    assign stage_q[0].src   = plain_second_word;

    for (genvar s = 0; s < Latency; s++)
    begin : g_stage
        localparam word_t StageSum = round_sum(7'(s / 2));
        localparam bit    SecondHalf = (s % 2) == 1;

        tvbe_half_round u_half_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .sum       (StageSum),
            .key_a     (SecondHalf ? key2 : key0),
            .key_b     (SecondHalf ? key3 : key1),
            .stage_in  (stage_q[s]),
            .stage_out (stage_q[s+1])
        );
    end

    assign done               = stage_q[Latency].valid;
    assign cipher_first_word  = stage_q[Latency].upd;
    assign cipher_second_word = stage_q[Latency].src;

    `ASSERT_IMPLIES(done_follows_request, clk, rst_n, done, $past(start, Latency))
    `ASSERT_NEXT(request_enters_pipe, clk, rst_n, start, stage_q[1].valid)

endmodule
